/* hdl/assert_macros.svh */
// assertion macros for the rtl of the console cell writer
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hdl/tccw_pkg.sv */
// package for the text console cell writer: screen geometry, codes, word types
// no dependencies
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);

  // widths of the word fields
  localparam int FIELD_ROW_W = 5;
  localparam int FIELD_COL_W = 7;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h8A;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_e;

  typedef struct packed {
    logic                   op;
    logic [7:0]             char_code;
    logic [FIELD_ROW_W-1:0] read_row;
    logic [FIELD_COL_W-1:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [15:0]            cell_value;
    logic [FIELD_ROW_W-1:0] cursor_row_now;
    logic [FIELD_COL_W-1:0] cursor_col_now;
    logic                   scrolled;
  } out_word_t;

endpackage

`default_nettype wire

/* hdl/text_console_cell_writer.sv */
// text console cell writer: screen store in one synchronous ram, cursor and scroll control
// depends on tccw_pkg and assert_macros.svh
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------------
//  input    | start_i, busy_o, in_i          | word taken when start_i and !busy_o
//  result   | done_o, result_o               | one-cycle strobe, cannot be held off
//  config   | cfg_we_i, cfg_data_i           | text colour written when cfg_we_i
//
// flow: a put without scroll is done in ST_IDLE, a read passes ST_READ (registered ram read),
//   a put that scrolls passes ST_FILL (one ram write per cell of the new blank row)
// reset: a clearing pass walks all ROWS*COLUMNS (2000) cells of the ram writing blank
//   cells; busy_o stays high through it, colour writes are still taken
// scrolling moves no data: a top-row offset rotates and only the freed row is blanked
// results come from registers: a put answers in the cycle after it is taken, a read
//   once ST_READ has passed, a scroll in the cycle after the last blank cell
`default_nettype none

module text_console_cell_writer
  import tccw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire in_word_t   in_i,
  output logic            done_o,
  output out_word_t       result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i
);

  `include "assert_macros.svh"

  // control and cursor state
  state_e              state_q, state_d;
  logic [7:0]          color_q;
  logic [ROW_W-1:0]    cur_row_q, cur_row_d;
  logic [COL_W-1:0]    cur_col_q, cur_col_d;
  logic [ROW_W-1:0]    base_q, base_d;      // physical row holding logical row 0
  logic [ADDR_W-1:0]   cnt_q, cnt_d;        // sweep counter for clear and row fill
  logic [ADDR_W-1:0]   fill_base_q, fill_base_d;
  logic                rd_ok_q, rd_ok_d;
  out_word_t           result_q, result_d;
  logic                done_q, done_d;

  // screen ram, single port, registered read
  logic [15:0]         mem [CELLS];
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [15:0]         mem_wdata;
  logic [15:0]         rdata_q;

  // decoded item and cursor step
  logic                accept;
  logic                is_nl;
  logic [COL_W:0]      col_inc;
  logic                wrap;
  logic                scroll_now;
  logic                rd_in_range;
  logic                clear_last;
  logic                fill_last;

  // logical row to physical row through the rotating offset
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, b};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] r);
    return ADDR_W'(r) * ADDR_W'(COLUMNS);
  endfunction

  assign accept      = start_i && (state_q == ST_IDLE);
  assign is_nl       = (in_i.char_code == NEWLINE_CODE);
  assign col_inc     = {1'b0, cur_col_q} + (COL_W+1)'(1);
  assign wrap        = is_nl || (col_inc >= (COL_W+1)'(COLUMNS));
  assign scroll_now  = wrap && (cur_row_q == ROW_W'(ROWS - 1));
  assign rd_in_range = (32'(in_i.read_row) < ROWS) && (32'(in_i.read_col) < COLUMNS);
  assign clear_last  = (cnt_q == ADDR_W'(CELLS - 1));
  assign fill_last   = (cnt_q == ADDR_W'(COLUMNS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_i.op == OP_READ) begin
            state_d = ST_READ;
          end else if (scroll_now) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_FILL: begin
        if (fill_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ram control, cursor update and result word
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = {color_q, SPACE_CODE};
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    fill_base_d = fill_base_q;
    rd_ok_d     = rd_ok_q;
    result_d    = result_q;
    done_d      = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // blank every cell in the reset colour
        mem_we    = 1'b1;
        mem_addr  = cnt_q;
        mem_wdata = {RESET_COLOR, SPACE_CODE};
        cnt_d     = clear_last ? '0 : cnt_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_i.op == OP_READ) begin
            rd_ok_d  = rd_in_range;
            mem_re   = rd_in_range;
            mem_addr = row_addr(phys_row(ROW_W'(in_i.read_row), base_q))
                       + ADDR_W'(in_i.read_col);
          end else begin
            // character goes at the cursor, newline is not stored
            mem_we    = !is_nl;
            mem_addr  = row_addr(phys_row(cur_row_q, base_q)) + ADDR_W'(cur_col_q);
            mem_wdata = {color_q, in_i.char_code};
            if (wrap) begin
              cur_col_d = '0;
              if (scroll_now) begin
                // old top row becomes the new bottom row, blanked in ST_FILL
                fill_base_d = row_addr(base_q);
                base_d      = (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + ROW_W'(1);
              end else begin
                cur_row_d = cur_row_q + ROW_W'(1);
              end
            end else begin
              cur_col_d = col_inc[COL_W-1:0];
            end
            if (!scroll_now) begin
              done_d                  = 1'b1;
              result_d.cell_value     = '0;
              result_d.cursor_row_now = FIELD_ROW_W'(cur_row_d);
              result_d.cursor_col_now = FIELD_COL_W'(cur_col_d);
              result_d.scrolled       = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        done_d                  = 1'b1;
        result_d.cell_value     = rd_ok_q ? rdata_q : 16'h0000;
        result_d.cursor_row_now = FIELD_ROW_W'(cur_row_q);
        result_d.cursor_col_now = FIELD_COL_W'(cur_col_q);
        result_d.scrolled       = 1'b0;
      end
      ST_FILL: begin
        // blank the new bottom row in the current colour
        mem_we    = 1'b1;
        mem_addr  = fill_base_q + cnt_q;
        mem_wdata = {color_q, SPACE_CODE};
        if (fill_last) begin
          cnt_d                   = '0;
          done_d                  = 1'b1;
          result_d.cell_value     = '0;
          result_d.cursor_row_now = FIELD_ROW_W'(cur_row_q);
          result_d.cursor_col_now = FIELD_COL_W'(cur_col_q);
          result_d.scrolled       = 1'b1;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      color_q   <= RESET_COLOR;
      cur_row_q <= '0;
      cur_col_q <= '0;
      base_q    <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      base_q    <= base_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fill_base_q <= fill_base_d;
    rd_ok_q     <= rd_ok_d;
    result_q    <= result_d;
  end

  // screen ram
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // a read always answers in the cycle after its ST_READ state
  `ASSERT_CLK(a_read_answers, (state_q == ST_READ) |=> done_q, "read gave no result")
  // a scroll result only ever closes a row fill
  `ASSERT_CLK(a_scroll_after_fill, (done_q && result_q.scrolled) |-> ($past(state_q) == ST_FILL),
    "scroll flagged without row fill")
  // a put that does not scroll answers at once
  `ASSERT_CLK(a_put_answers,
    (accept && (in_i.op == OP_PUT) && !scroll_now) |=> (done_q && (state_q == ST_IDLE)),
    "put without scroll gave no result")
  // cursor and row offset stay on the screen
  `ASSERT_NEVER(a_cursor_range,
    (32'(cur_row_q) >= ROWS) || (32'(cur_col_q) >= COLUMNS) || (32'(base_q) >= ROWS),
    "cursor or row offset off screen")

endmodule

`default_nettype wire

/* tb/text_console_cell_writer_test.sv */
// self-checking testbench for the text console cell writer: directed and random put/read words
// with a screen shadow that predicts every result; depends on tccw_pkg and the writer rtl
module text_console_cell_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  // cycles with no word taken, no result and no colour write before giving up;
  // covers the clearing pass after reset with plenty of margin
  localparam int unsigned IDLE_LIMIT = 20000;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       start_i    = 1'b0;
  logic       busy_o;
  in_word_t   in_i       = '0;
  logic       done_o;
  out_word_t  result_o;
  logic       cfg_we_i   = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;

  // shadow of the screen, cursor and colour register
  logic [15:0] screen_shadow [ROWS][COLUMNS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_byte;

  out_word_t   expected_reports [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  bit          start_high  = 1'b0;

  text_console_cell_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // applies one word to the shadow and returns the result it should produce
  function automatic out_word_t console_predict(input in_word_t w);
    out_word_t r;
    int        rr;
    int        cc;
    r = '0;
    if (w.op == OP_READ) begin
      // outside the screen reads back as zero
      if (int'(w.read_row) < ROWS && int'(w.read_col) < COLUMNS) begin
        r.cell_value = screen_shadow[w.read_row][w.read_col];
      end
    end else begin
      // a newline only moves the cursor
      if (w.char_code != NEWLINE_CODE) begin
        screen_shadow[cur_row][cur_col] = {attr_byte, w.char_code};
      end
      cur_col++;
      if (cur_col >= COLUMNS || w.char_code == NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
          // shift up one row, blank the bottom row in the current colour
          for (rr = 0; rr < ROWS - 1; rr++) begin
            for (cc = 0; cc < COLUMNS; cc++) begin
              screen_shadow[rr][cc] = screen_shadow[rr + 1][cc];
            end
          end
          for (cc = 0; cc < COLUMNS; cc++) begin
            screen_shadow[ROWS - 1][cc] = {attr_byte, SPACE_CODE};
          end
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
    end
    r.cursor_row_now = FIELD_ROW_W'(cur_row);
    r.cursor_col_now = FIELD_COL_W'(cur_col);
    return r;
  endfunction

  function automatic in_word_t put_word(input logic [7:0] ch);
    in_word_t w;
    w.op        = OP_PUT;
    w.char_code = ch;
    // row and column are don't-care on a put, so keep them moving
    w.read_row  = FIELD_ROW_W'($urandom);
    w.read_col  = FIELD_COL_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_at(input int row, input int col);
    in_word_t w;
    w.op        = OP_READ;
    w.char_code = 8'($urandom);
    w.read_row  = FIELD_ROW_W'(row);
    w.read_col  = FIELD_COL_W'(col);
    return w;
  endfunction

  // often cells just written on the cursor row, some anywhere, some over the full field range
  function automatic in_word_t random_read();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return read_at(cur_row, cur_col == 0 ? 0 : $urandom_range(0, cur_col - 1));
    end
    if (pick < 85) begin
      return read_at($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
    end
    return read_at($urandom_range(0, (1 << FIELD_ROW_W) - 1),
                   $urandom_range(0, (1 << FIELD_COL_W) - 1));
  endfunction

  // any byte but a newline
  function automatic logic [7:0] random_glyph();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while (ch == NEWLINE_CODE);
    return ch;
  endfunction

  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 99) < 12) begin
      return NEWLINE_CODE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // drops start only if it is up, so start never sees two assignments in one step
  task automatic release_start();
    if (start_high) begin
      start_i   <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  // offers one word, waits until it is taken, predicts it, then paces the sender
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    start_i   <= 1'b1;
    in_i      <= w;
    start_high = 1'b1;
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    expected_reports.push_back(console_predict(w));

    // bursts of random length, then a random gap; some gaps are zero so that
    // long unbroken stretches also occur
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) :
                                                  $urandom_range(1, 30);
      case ($urandom_range(0, 9))
        0, 1:       gap = 0;
        2, 3, 4, 5: gap = $urandom_range(1, 3);
        6, 7, 8:    gap = $urandom_range(4, 15);
        default:    gap = $urandom_range(20, 90);
      endcase
      if (gap > 0) begin
        release_start();
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // idle the block: every awaited word back and busy low
  task automatic drain_block();
    release_start();
    while (expected_reports.size() != 0 || busy_o !== 1'b0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_colour(input logic [7:0] colour);
    drain_block();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= colour;
    @(posedge clk_i);
    attr_byte = colour;
    cfg_we_i <= 1'b0;
  endtask

  // screen contents left by the clearing pass, plus reads off the screen
  task automatic test_reset_screen();
    send_word(read_at(0, 0));
    send_word(read_at(ROWS - 1, COLUMNS - 1));
    send_word(read_at(ROWS / 2, COLUMNS / 2));
    send_word(read_at(ROWS, 0));
    send_word(read_at(0, COLUMNS));
    send_word(read_at((1 << FIELD_ROW_W) - 1, (1 << FIELD_COL_W) - 1));
  endtask

  // extreme colour and character bytes, and a newline that stores nothing
  task automatic test_colour_extremes();
    write_colour(8'h00);
    send_word(put_word(8'h00));
    write_colour(8'hFF);
    send_word(put_word(8'hFF));
    send_word(put_word(NEWLINE_CODE));
    send_word(read_at(0, 0));
    send_word(read_at(0, 1));
    send_word(read_at(0, 2));
    send_word(read_at(1, 0));
  endtask

  // short lines ended by newlines, enough of them to scroll several times
  task automatic test_scroll_lines();
    int line_no;
    int len;
    write_colour(8'($urandom_range(0, 255)));
    for (line_no = 0; line_no < 30; line_no++) begin
      // blank rows made from here on take a fresh colour
      if (line_no == 26) begin
        write_colour(8'($urandom_range(0, 255)));
      end
      len = $urandom_range(0, 10);
      repeat (len) send_word(put_word(random_glyph()));
      send_word(put_word(NEWLINE_CODE));
      send_word(read_at(cur_row == 0 ? 0 : cur_row - 1, $urandom_range(0, 11)));
      send_word(read_at(ROWS - 1, $urandom_range(0, COLUMNS - 1)));
    end
  endtask

  // runs of a row or longer: column wrap, and scrolls caused by the wrap
  task automatic test_line_wrap();
    int run_no;
    int run_len;
    for (run_no = 0; run_no < 3; run_no++) begin
      write_colour(run_no == 0 ? RESET_COLOR : 8'($urandom_range(0, 255)));
      run_len = $urandom_range(COLUMNS, 2 * COLUMNS + 20);
      repeat (run_len) send_word(put_word(random_glyph()));
      repeat (4) send_word(random_read());
    end
  endtask

  // mixed puts and reads over several colour settings
  task automatic test_random_mix();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_colour(8'h0F);
        1:       write_colour(8'hF0);
        default: write_colour(8'($urandom_range(0, 255)));
      endcase
      repeat (150) begin
        if ($urandom_range(0, 99) < 60) begin
          send_word(put_word(random_char()));
        end else begin
          send_word(random_read());
        end
      end
    end
  endtask

  // result words are compared field by field with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("word with nothing awaited", 32'(result_o), 0);
      end else begin
        want = expected_reports.pop_front();
        if (result_o.cell_value !== want.cell_value) begin
          report_mismatch("cell_value", 32'(result_o.cell_value), 32'(want.cell_value));
        end
        if (result_o.cursor_row_now !== want.cursor_row_now) begin
          report_mismatch("cursor_row_now", 32'(result_o.cursor_row_now),
                          32'(want.cursor_row_now));
        end
        if (result_o.cursor_col_now !== want.cursor_col_now) begin
          report_mismatch("cursor_col_now", 32'(result_o.cursor_col_now),
                          32'(want.cursor_col_now));
        end
        if (result_o.scrolled !== want.scrolled) begin
          report_mismatch("scrolled", 32'(result_o.scrolled), 32'(want.scrolled));
        end
      end
    end
  end

  // stops a hung run: counts cycles with no activity on any channel
  always @(posedge clk_i) begin : watchdog
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1 || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[text_console_cell_writer] ERROR");
      $finish;
    end
  end

  initial begin : run_tests
    int rr;
    int cc;
    // shadow starts as the cleared screen
    for (rr = 0; rr < ROWS; rr++) begin
      for (cc = 0; cc < COLUMNS; cc++) begin
        screen_shadow[rr][cc] = {RESET_COLOR, SPACE_CODE};
      end
    end
    cur_row   = 0;
    cur_col   = 0;
    attr_byte = RESET_COLOR;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_screen();
    test_colour_extremes();
    test_scroll_lines();
    test_line_wrap();
    test_random_mix();

    // let any stray late word show up before the verdict
    drain_block();
    repeat (COLUMNS + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[text_console_cell_writer] OK");
    end else begin
      $display("[text_console_cell_writer] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/tccw_pkg.sv
hdl/text_console_cell_writer.sv
tb/text_console_cell_writer_test.sv
